@@ rtl/core/bsp_pkg.sv @@
// Shared types, codes and defaults for the B-spline basis evaluator.
// Depends on nothing; every other file in rtl/core but bsp_ram refers to it by scoped name.
`timescale 1ns / 1ps

package bsp_pkg;

	// Defaults for the top-level parameters.
	localparam int DEF_MAX_BREAKPOINTS = 16;
	localparam int DEF_MAX_ORDER       = 3;
	localparam int DEF_FRAC_BITS       = 16;

	// The recursion never goes deeper than degree three, so four slots hold a triangle row.
	localparam int SLOT_COUNT = 4;

	// Transaction kinds.
	localparam logic [2:0] KIND_LOAD        = 3'd0;
	localparam logic [2:0] KIND_VALUE       = 3'd1;
	localparam logic [2:0] KIND_DERIV       = 3'd2;
	localparam logic [2:0] KIND_ALL_VALUES  = 3'd3;
	localparam logic [2:0] KIND_ALL_DERIVS  = 3'd4;

	// Result status codes.
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_RANGE = 2'd1;
	localparam logic [1:0] STATUS_DEG0  = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SPLINE_ORDER     = 2'd0;
	localparam logic [1:0] CFG_BREAKPOINT_COUNT = 2'd1;
	localparam logic [1:0] CFG_TOLERANCE        = 2'd2;

	// Configuration reset values.
	localparam logic [1:0]  RST_SPLINE_ORDER     = 2'd3;
	localparam logic [4:0]  RST_BREAKPOINT_COUNT = 5'd2;
	localparam logic [15:0] RST_TOLERANCE        = 16'd1;

	typedef struct packed {
		logic [2:0]         kind;
		logic [3:0]         breakpoint_index;
		logic signed [31:0] point_value;
		logic [4:0]         basis_index;
		logic [1:0]         degree;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [4:0]         result_index;
		logic               last;
		logic [1:0]         status;
	} out_item_t;

	// Request to the shared multiply-divide unit: sat(num * scale / den).
	typedef struct packed {
		logic               start;
		logic signed [33:0] num;
		logic signed [31:0] scale;
		logic signed [33:0] den;
	} md_req_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] quot;
	} md_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PRE,
		S_PRE_W,
		S_CHECK,
		S_START,
		S_FETCH_P,
		S_FETCH_Q,
		S_GOT_Q,
		S_EVAL,
		S_WAIT,
		S_TERM,
		S_FINISH,
		S_EMIT
	} seq_state_t;

	typedef enum logic [1:0] {
		U_IDLE,
		U_MUL,
		U_DIV,
		U_SAT
	} md_state_t;

	// Saturate a wide signed value to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sh0_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -36'sh0_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/core/bsp_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module bsp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/bsp_muldiv.sv @@
// Shared sequential unit computing sat32(num * scale / den), truncated toward zero.
// Depends on bsp_pkg for the request and response structs and the state type.
`timescale 1ns / 1ps

module bsp_muldiv (
	input  logic             clk,
	input  logic             arst_n,
	input  bsp_pkg::md_req_t req,
	output bsp_pkg::md_rsp_t rsp
);

	bsp_pkg::md_state_t state_q, state_d;
	logic [6:0]  cnt_q;
	logic        done_q;
	logic        neg_q;
	logic [33:0] ud_q;
	logic [65:0] mcand_q;
	logic [31:0] mplier_q;
	logic [65:0] work_q;
	logic [34:0] rem_q;
	logic signed [31:0] quot_q;

	logic [33:0] ua, ud;
	logic [31:0] ub;
	logic [34:0] rem_sh, rem_sub;
	logic        fits;
	logic signed [31:0] sat_val;

	// Operand magnitudes; the sign of the quotient is kept apart.
	always_comb begin
		ua = req.num[33] ? 34'(-req.num) : 34'(req.num);
		ub = req.scale[31] ? 32'(-req.scale) : 32'(req.scale);
		ud = req.den[33] ? 34'(-req.den) : 34'(req.den);
	end

	// One restoring division step.
	always_comb begin
		rem_sh  = {rem_q[33:0], work_q[65]};
		fits    = rem_sh >= {1'b0, ud_q};
		rem_sub = rem_sh - {1'b0, ud_q};
	end

	// Saturation of the unsigned quotient with its sign applied.
	always_comb begin
		if (!neg_q) begin
			sat_val = (work_q > 66'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : work_q[31:0];
		end else begin
			sat_val = (work_q >= 66'h0_8000_0000) ? 32'sh8000_0000 : 32'(-work_q[31:0]);
		end
	end

	// Next state: a shift-add multiply, then a restoring division, then saturation.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bsp_pkg::U_IDLE: if (req.start) state_d = bsp_pkg::U_MUL;
			bsp_pkg::U_MUL:  if (cnt_q == 7'd31) state_d = bsp_pkg::U_DIV;
			bsp_pkg::U_DIV:  if (cnt_q == 7'd65) state_d = bsp_pkg::U_SAT;
			bsp_pkg::U_SAT:  state_d = bsp_pkg::U_IDLE;
			default:         state_d = bsp_pkg::U_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsp_pkg::U_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == bsp_pkg::U_SAT);
			if (state_q != state_d) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 7'd1;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			bsp_pkg::U_IDLE: begin
				if (req.start) begin
					neg_q    <= req.num[33] ^ req.scale[31] ^ req.den[33];
					ud_q     <= ud;
					mcand_q  <= 66'(ua);
					mplier_q <= ub;
					work_q   <= '0;
					rem_q    <= '0;
				end
			end
			bsp_pkg::U_MUL: begin
				if (mplier_q[0]) begin
					work_q <= work_q + mcand_q;
				end
				mcand_q  <= {mcand_q[64:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[31:1]};
			end
			bsp_pkg::U_DIV: begin
				rem_q  <= fits ? rem_sub : rem_sh;
				work_q <= {work_q[64:0], fits};
			end
			bsp_pkg::U_SAT: begin
				quot_q <= sat_val;
			end
			default: begin
			end
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

@@ rtl/core/bspline_basis_eval_unit.sv @@
// Top level of the B-spline basis evaluator: sequencer, breakpoint store, output register.
// Depends on bsp_pkg, bsp_ram and bsp_muldiv.
`timescale 1ns / 1ps

// Evaluates Cox-de Boor B-spline basis values and derivatives in signed fixed point
// with FRAC_BITS fraction bits. A load transaction writes one breakpoint. An
// evaluation takes the breakpoint store through one read port, builds the degree-zero
// row and then the triangle term by term on one shared multiply-divide unit; each term
// reads two knots, and a term that is not dropped then goes through a shift-add multiply
// and a restoring divide on the unit. A basis value of degree k needs up to k(k+1) terms,
// and a full run repeats this for each of its count+order-1 results. The input is stalled
// for the whole evaluation; results leave through a one-deep output register.
// There is no clearing pass: breakpoints must be loaded before they are used.
module bspline_basis_eval_unit #(
	parameter int MAX_BREAKPOINTS = bsp_pkg::DEF_MAX_BREAKPOINTS,
	parameter int MAX_ORDER       = bsp_pkg::DEF_MAX_ORDER,
	parameter int FRAC_BITS       = bsp_pkg::DEF_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  bsp_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output bsp_pkg::out_item_t out_item,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int KNOT_CAP = MAX_BREAKPOINTS + 2 * MAX_ORDER;
	localparam int KW       = $clog2(KNOT_CAP + 36);
	localparam int SW       = $clog2(MAX_BREAKPOINTS);
	localparam logic signed [31:0] ONE = 32'(64'(1) << FRAC_BITS);

	// Configuration registers.
	logic [1:0]  spline_order_q;
	logic [4:0]  breakpoint_count_q;
	logic [15:0] tolerance_q;

	// Sequencer state and working registers.
	bsp_pkg::seq_state_t state_q, state_d;
	logic signed [31:0] x_q;
	logic [KW-1:0]      base_q;
	logic [1:0]         deg_q;
	logic               deriv_q;
	logic               full_q;
	logic               zero_run_q;
	logic               closed_q;
	logic [1:0]         lvl_q;
	logic [1:0]         m_q;
	logic               term_q;
	logic               top_q;
	logic               last_q;
	logic [1:0]         st_q;
	logic signed [31:0] pk_q, qk_q;
	logic signed [31:0] c1_q, tval_q, res_q;
	logic signed [31:0] slot_q [bsp_pkg::SLOT_COUNT];

	// Output register.
	logic               out_valid_q;
	bsp_pkg::out_item_t out_item_q;

	logic [1:0]     ord_w;
	logic [KW-1:0]  cnt_w, ktot_w, run_tot_w, j_w, pidx_w, qidx_w;
	logic [1:0]     vlev_w;
	logic           lvl0_w, skip_w, ind_w, last_m_w, range_err_w, out_load;
	logic           accept_w, eval_kind_w, load_we;
	logic [SW-1:0]  raddr;
	logic [31:0]    rd_data;
	logic signed [31:0] cur_w, r_sum_w, r_der_w;
	logic signed [35:0] diff_w;
	logic [2:0]     n_prev_w;
	bsp_pkg::md_req_t md_req;
	bsp_pkg::md_rsp_t md_rsp;

	// Knot index to breakpoint address, with the end padding folded in.
	function automatic logic [SW-1:0] knot_addr(input logic [KW-1:0] j,
			input logic [KW-1:0] ord, input logic [KW-1:0] cnt);
		logic [KW-1:0] s;
		if (j < ord) begin
			s = '0;
		end else if (j < ord + cnt) begin
			s = j - ord;
		end else begin
			s = cnt - KW'(1);
		end
		return SW'(s);
	endfunction

	// Two values are equal when they differ by at most the tolerance.
	function automatic logic near_eq(input logic signed [31:0] a, input logic signed [31:0] b,
			input logic [15:0] tol);
		logic signed [32:0] d;
		d = 33'(a) - 33'(b);
		if (d < 0) begin
			d = -d;
		end
		return $unsigned(d) <= 33'(tol);
	endfunction

	// Configuration write port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spline_order_q     <= bsp_pkg::RST_SPLINE_ORDER;
			breakpoint_count_q <= bsp_pkg::RST_BREAKPOINT_COUNT;
			tolerance_q        <= bsp_pkg::RST_TOLERANCE;
		end else if (cfg_write) begin
			unique case (cfg_index)
				bsp_pkg::CFG_SPLINE_ORDER:     spline_order_q     <= cfg_data[1:0];
				bsp_pkg::CFG_BREAKPOINT_COUNT: breakpoint_count_q <= cfg_data[4:0];
				bsp_pkg::CFG_TOLERANCE:        tolerance_q        <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Effective order and count, and the knot vector lengths derived from them.
	always_comb begin
		ord_w = (32'(spline_order_q) > MAX_ORDER) ? 2'(MAX_ORDER) : spline_order_q;
		if (breakpoint_count_q < 5'd2) begin
			cnt_w = KW'(2);
		end else if (32'(breakpoint_count_q) > MAX_BREAKPOINTS) begin
			cnt_w = KW'(MAX_BREAKPOINTS);
		end else begin
			cnt_w = KW'(breakpoint_count_q);
		end
		ktot_w    = cnt_w + (KW'(ord_w) << 1);
		run_tot_w = cnt_w + KW'(ord_w) - KW'(1);
	end

	// Knot indexes for the current term.
	always_comb begin
		j_w    = base_q + KW'(m_q);
		lvl0_w = (lvl_q == 2'd0) && !top_q;
		if (lvl0_w) begin
			pidx_w = j_w;
			qidx_w = j_w + KW'(1);
		end else if (top_q) begin
			pidx_w = term_q ? base_q + KW'(1) : base_q;
			qidx_w = base_q + KW'(deg_q) + (term_q ? KW'(1) : KW'(0));
		end else if (!term_q) begin
			pidx_w = j_w;
			qidx_w = j_w + KW'(lvl_q);
		end else begin
			pidx_w = j_w + KW'(lvl_q) + KW'(1);
			qidx_w = j_w + KW'(1);
		end
		if (state_q == bsp_pkg::S_PRE) begin
			raddr = SW'(cnt_w - KW'(1));
		end else if (state_q == bsp_pkg::S_FETCH_P) begin
			raddr = knot_addr(pidx_w, KW'(ord_w), cnt_w);
		end else begin
			raddr = knot_addr(qidx_w, KW'(ord_w), cnt_w);
		end
	end

	// Term evaluation helpers.
	always_comb begin
		vlev_w      = deriv_q ? deg_q - 2'd1 : deg_q;
		skip_w      = near_eq(qk_q, pk_q, tolerance_q);
		ind_w       = ((x_q > pk_q) || near_eq(x_q, pk_q, tolerance_q))
			&& (closed_q ? ((x_q < qk_q) || near_eq(x_q, qk_q, tolerance_q)) : (x_q < qk_q));
		last_m_w    = (m_q == deg_q - lvl_q);
		n_prev_w    = 3'(deg_q) - 3'(lvl_q) + 3'd2;
		range_err_w = (base_q + KW'(deg_q) + KW'(1)) >= ktot_w;
		cur_w       = term_q ? slot_q[1] : slot_q[0];
		r_sum_w     = bsp_pkg::sat32(36'(c1_q) + 36'(tval_q));
		diff_w      = 36'(c1_q) - 36'(tval_q);
		r_der_w     = bsp_pkg::sat32($signed(diff_w * 36'(deg_q)));
	end

	// Request to the shared unit.
	always_comb begin
		md_req.start = (state_q == bsp_pkg::S_EVAL) && !lvl0_w && !skip_w;
		md_req.num   = top_q ? 34'(cur_w) : 34'(x_q) - 34'(pk_q);
		md_req.scale = top_q ? ONE : cur_w;
		md_req.den   = 34'(qk_q) - 34'(pk_q);
	end

	assign eval_kind_w = (in_item.kind == bsp_pkg::KIND_VALUE)
		|| (in_item.kind == bsp_pkg::KIND_DERIV)
		|| (in_item.kind == bsp_pkg::KIND_ALL_VALUES)
		|| (in_item.kind == bsp_pkg::KIND_ALL_DERIVS);
	assign accept_w = in_valid && (state_q == bsp_pkg::S_IDLE);
	assign load_we  = accept_w && (in_item.kind == bsp_pkg::KIND_LOAD)
		&& (32'(in_item.breakpoint_index) < MAX_BREAKPOINTS);
	assign out_load = (state_q == bsp_pkg::S_EMIT) && (!out_valid_q || !out_stall);

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bsp_pkg::S_IDLE:    if (in_valid && eval_kind_w) state_d = bsp_pkg::S_PRE;
			bsp_pkg::S_PRE:     state_d = bsp_pkg::S_PRE_W;
			bsp_pkg::S_PRE_W:   state_d = bsp_pkg::S_CHECK;
			bsp_pkg::S_CHECK: begin
				if (full_q) begin
					state_d = (deriv_q && ord_w == 2'd0) ? bsp_pkg::S_EMIT : bsp_pkg::S_START;
				end else if ((deriv_q && deg_q == 2'd0) || range_err_w) begin
					state_d = bsp_pkg::S_EMIT;
				end else begin
					state_d = bsp_pkg::S_START;
				end
			end
			bsp_pkg::S_START:   state_d = bsp_pkg::S_FETCH_P;
			bsp_pkg::S_FETCH_P: state_d = bsp_pkg::S_FETCH_Q;
			bsp_pkg::S_FETCH_Q: state_d = bsp_pkg::S_GOT_Q;
			bsp_pkg::S_GOT_Q:   state_d = bsp_pkg::S_EVAL;
			bsp_pkg::S_EVAL: begin
				if (lvl0_w) begin
					if (m_q == deg_q && lvl_q == vlev_w && !deriv_q) begin
						state_d = bsp_pkg::S_FINISH;
					end else begin
						state_d = bsp_pkg::S_FETCH_P;
					end
				end else begin
					state_d = skip_w ? bsp_pkg::S_TERM : bsp_pkg::S_WAIT;
				end
			end
			bsp_pkg::S_WAIT:    if (md_rsp.done) state_d = bsp_pkg::S_TERM;
			bsp_pkg::S_TERM: begin
				if (!term_q) begin
					state_d = bsp_pkg::S_FETCH_P;
				end else if (top_q) begin
					state_d = bsp_pkg::S_EMIT;
				end else if (last_m_w && lvl_q == vlev_w && !deriv_q) begin
					state_d = bsp_pkg::S_FINISH;
				end else begin
					state_d = bsp_pkg::S_FETCH_P;
				end
			end
			bsp_pkg::S_FINISH:  state_d = bsp_pkg::S_EMIT;
			bsp_pkg::S_EMIT: begin
				if (out_load) begin
					if (last_q) begin
						state_d = bsp_pkg::S_IDLE;
					end else if (zero_run_q) begin
						state_d = bsp_pkg::S_EMIT;
					end else begin
						state_d = bsp_pkg::S_START;
					end
				end
			end
			default:            state_d = bsp_pkg::S_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bsp_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the sequencer.
	always_ff @(posedge clk) begin
		unique case (state_q)
			bsp_pkg::S_IDLE: begin
				if (accept_w && eval_kind_w) begin
					x_q        <= in_item.point_value;
					base_q     <= KW'(in_item.basis_index);
					deg_q      <= in_item.degree;
					deriv_q    <= (in_item.kind == bsp_pkg::KIND_DERIV)
						|| (in_item.kind == bsp_pkg::KIND_ALL_DERIVS);
					full_q     <= (in_item.kind == bsp_pkg::KIND_ALL_VALUES)
						|| (in_item.kind == bsp_pkg::KIND_ALL_DERIVS);
					zero_run_q <= 1'b0;
				end
			end
			bsp_pkg::S_PRE_W: begin
				closed_q <= near_eq(x_q, $signed(rd_data), tolerance_q);
			end
			bsp_pkg::S_CHECK: begin
				res_q <= '0;
				if (full_q) begin
					base_q <= '0;
					deg_q  <= ord_w;
					last_q <= (run_tot_w == KW'(1));
					if (deriv_q && ord_w == 2'd0) begin
						zero_run_q <= 1'b1;
						st_q       <= bsp_pkg::STATUS_DEG0;
					end
				end else begin
					last_q <= 1'b1;
					if (deriv_q && deg_q == 2'd0) begin
						st_q <= bsp_pkg::STATUS_DEG0;
					end else if (range_err_w) begin
						st_q <= bsp_pkg::STATUS_RANGE;
					end
				end
			end
			bsp_pkg::S_START: begin
				lvl_q  <= '0;
				m_q    <= '0;
				term_q <= 1'b0;
				top_q  <= 1'b0;
			end
			bsp_pkg::S_FETCH_Q: pk_q <= $signed(rd_data);
			bsp_pkg::S_GOT_Q:   qk_q <= $signed(rd_data);
			bsp_pkg::S_EVAL: begin
				if (lvl0_w) begin
					// Degree-zero row: one indicator per knot interval.
					slot_q[m_q] <= ind_w ? ONE : 32'sd0;
					if (m_q == deg_q) begin
						m_q    <= '0;
						term_q <= 1'b0;
						if (lvl_q == vlev_w) begin
							if (deriv_q) begin
								top_q <= 1'b1;
							end
						end else begin
							lvl_q <= lvl_q + 2'd1;
						end
					end else begin
						m_q <= m_q + 2'd1;
					end
				end else if (skip_w) begin
					tval_q <= '0;
				end
			end
			bsp_pkg::S_WAIT: begin
				if (md_rsp.done) begin
					tval_q <= md_rsp.quot;
				end
			end
			bsp_pkg::S_TERM: begin
				if (!term_q) begin
					c1_q   <= tval_q;
					term_q <= 1'b1;
				end else if (top_q) begin
					res_q <= r_der_w;
					st_q  <= bsp_pkg::STATUS_OK;
				end else begin
					// Consume the row head and queue the new value behind the rest.
					term_q <= 1'b0;
					if (last_m_w) begin
						for (int i = 0; i < bsp_pkg::SLOT_COUNT - 2; i++) begin
							slot_q[i] <= slot_q[i + 2];
						end
						slot_q[2'(n_prev_w - 3'd2)] <= r_sum_w;
						m_q <= '0;
						if (lvl_q == vlev_w) begin
							if (deriv_q) begin
								top_q <= 1'b1;
							end
						end else begin
							lvl_q <= lvl_q + 2'd1;
						end
					end else begin
						for (int i = 0; i < bsp_pkg::SLOT_COUNT - 1; i++) begin
							slot_q[i] <= slot_q[i + 1];
						end
						slot_q[2'(n_prev_w - 3'd1)] <= r_sum_w;
						m_q <= m_q + 2'd1;
					end
				end
			end
			bsp_pkg::S_FINISH: begin
				res_q <= slot_q[0];
				st_q  <= bsp_pkg::STATUS_OK;
			end
			bsp_pkg::S_EMIT: begin
				if (out_load && !last_q) begin
					base_q <= base_q + KW'(1);
					last_q <= (base_q + KW'(2) == run_tot_w);
				end
			end
			default: begin
			end
		endcase
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_item_q.result_value <= res_q;
			out_item_q.result_index <= 5'(base_q);
			out_item_q.last         <= last_q;
			out_item_q.status       <= st_q;
		end
	end

	bsp_ram #(
		.WIDTH(32),
		.DEPTH(MAX_BREAKPOINTS)
	) u_store (
		.clk  (clk),
		.we   (load_we),
		.waddr(SW'(in_item.breakpoint_index)),
		.wdata(in_item.point_value),
		.raddr(raddr),
		.rdata(rd_data)
	);

	bsp_muldiv u_muldiv (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (md_req),
		.rsp   (md_rsp)
	);

	assign in_stall  = (state_q != bsp_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

`ifndef SYNTH
	// The shared unit only finishes while the sequencer waits for it.
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		md_rsp.done |-> (state_q == bsp_pkg::S_WAIT))
		else $error("multiply-divide result arrived outside the wait state");

	// A new result only appears after the emit state.
	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == bsp_pkg::S_EMIT))
		else $error("result presented without passing the emit state");

	// The degree-zero row never goes through the divider.
	a_row0_no_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bsp_pkg::S_EVAL && lvl0_w) |-> !md_req.start)
		else $error("divider started for a degree-zero indicator");

	// No transaction is taken while an evaluation waits on the shared unit.
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bsp_pkg::S_WAIT) |=> in_stall)
		else $error("input taken during an evaluation");
`endif

endmodule

@@ tb/sv/bsp_checker.sv @@
// Result checker for the B-spline basis evaluator: watches the configuration port and both
// channels, predicts every result and compares it with what the unit delivers.
// Depends on bsp_pkg for the transaction types, kind codes, status codes and register indexes.
`timescale 1ns / 1ps

module bsp_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  bsp_pkg::in_item_t  in_item,
	input  logic               out_valid,
	input  logic               out_stall,
	input  bsp_pkg::out_item_t out_item,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output int                 fail_count,
	output int                 pending,
	output int                 results_checked
);

	localparam int      STORE_DEPTH = 16;
	localparam int      ORDER_CAP   = 3;
	localparam longint  FRAC_ONE    = 64'sd65536;

	// Predictor state: its own copy of the store and the registers.
	logic signed [31:0] bp_store [STORE_DEPTH];
	logic [1:0]         cur_order;
	logic [4:0]         cur_count;
	logic [15:0]        cur_tol;
	longint             knot_tab [STORE_DEPTH + 2 * ORDER_CAP];
	int                 knot_n;
	bsp_pkg::out_item_t expected_results [$];

	function automatic longint clip_word(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic bit knots_close(input longint a, input longint b);
		longint d;
		d = a - b;
		if (d < 0)
			d = -d;
		return d <= longint'(cur_tol);
	endfunction

	// a * b / d with truncation toward zero, saturated to a word.
	function automatic longint scaled_quot(input longint a, input longint b, input longint d);
		logic [95:0] ua, ub, ud, q;
		bit          neg;
		neg = ((a < 0) != (b < 0)) != (d < 0);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		ud = (d < 0) ? -d : d;
		q  = (ua * ub) / ud;
		if (!neg)
			return (q > 96'd2147483647) ? 64'sd2147483647 : longint'(q);
		if (q >= 96'd2147483648)
			return -64'sd2147483648;
		return -longint'(q);
	endfunction

	// Degree-zero basis: half-open interval, closed on the right at the last knot.
	function automatic longint step_basis(input longint x, input int i);
		bit lft, rgt;
		lft = (x > knot_tab[i]) || knots_close(x, knot_tab[i]);
		if (knots_close(x, knot_tab[knot_n - 1]))
			rgt = (x < knot_tab[i + 1]) || knots_close(x, knot_tab[i + 1]);
		else
			rgt = x < knot_tab[i + 1];
		return (lft && rgt) ? FRAC_ONE : 0;
	endfunction

	// Builds the triangle bottom-up; each row entry j holds the basis of index i + j.
	function automatic longint basis_at(input longint x, input int i, input int k);
		longint row [4];
		longint c1, c2;
		int     p;
		for (int j = 0; j <= k; j++)
			row[j] = step_basis(x, i + j);
		for (int d = 1; d <= k; d++) begin
			for (int j = 0; j <= k - d; j++) begin
				p  = i + j;
				c1 = 0;
				c2 = 0;
				if (!knots_close(knot_tab[p + d], knot_tab[p]))
					c1 = scaled_quot(x - knot_tab[p], row[j], knot_tab[p + d] - knot_tab[p]);
				if (!knots_close(knot_tab[p + d + 1], knot_tab[p + 1]))
					c2 = scaled_quot(x - knot_tab[p + d + 1], row[j + 1],
						knot_tab[p + 1] - knot_tab[p + d + 1]);
				row[j] = clip_word(c1 + c2);
			end
		end
		return row[0];
	endfunction

	function automatic longint slope_at(input longint x, input int i, input int k);
		longint c1, c2;
		c1 = 0;
		c2 = 0;
		if (!knots_close(knot_tab[i + k], knot_tab[i]))
			c1 = scaled_quot(basis_at(x, i, k - 1), FRAC_ONE, knot_tab[i + k] - knot_tab[i]);
		if (!knots_close(knot_tab[i + k + 1], knot_tab[i + 1]))
			c2 = scaled_quot(basis_at(x, i + 1, k - 1), FRAC_ONE,
				knot_tab[i + k + 1] - knot_tab[i + 1]);
		return clip_word(longint'(k) * (c1 - c2));
	endfunction

	function automatic bsp_pkg::out_item_t make_result(input longint v, input int idx,
			input bit lst, input logic [1:0] st);
		bsp_pkg::out_item_t r;
		r.result_value = v[31:0];
		r.result_index = idx[4:0];
		r.last         = lst;
		r.status       = st;
		return r;
	endfunction

	// Works out every result that one accepted transaction causes.
	task automatic predict_results(input bsp_pkg::in_item_t it);
		int     ord, cnt, total, bi, deg;
		longint x;
		ord = (cur_order > ORDER_CAP) ? ORDER_CAP : cur_order;
		cnt = cur_count;
		if (cnt < 2)
			cnt = 2;
		if (cnt > STORE_DEPTH)
			cnt = STORE_DEPTH;
		x   = it.point_value;
		bi  = it.basis_index;
		deg = it.degree;
		if (it.kind == bsp_pkg::KIND_LOAD) begin
			bp_store[it.breakpoint_index] = it.point_value;
			return;
		end
		if (it.kind > bsp_pkg::KIND_ALL_DERIVS)
			return;
		knot_n = cnt + 2 * ord;
		for (int j = 0; j < knot_n; j++)
			knot_tab[j] = bp_store[(j < ord) ? 0 : (j < ord + cnt) ? j - ord : cnt - 1];
		if (it.kind == bsp_pkg::KIND_VALUE || it.kind == bsp_pkg::KIND_DERIV) begin
			if (it.kind == bsp_pkg::KIND_DERIV && deg == 0)
				expected_results.push_back(make_result(0, bi, 1'b1, bsp_pkg::STATUS_DEG0));
			else if (bi + deg + 1 >= knot_n)
				expected_results.push_back(make_result(0, bi, 1'b1, bsp_pkg::STATUS_RANGE));
			else if (it.kind == bsp_pkg::KIND_VALUE)
				expected_results.push_back(make_result(basis_at(x, bi, deg), bi, 1'b1,
					bsp_pkg::STATUS_OK));
			else
				expected_results.push_back(make_result(slope_at(x, bi, deg), bi, 1'b1,
					bsp_pkg::STATUS_OK));
			return;
		end
		total = knot_n - 1 - ord;
		for (int j = 0; j < total; j++) begin
			if (it.kind == bsp_pkg::KIND_ALL_DERIVS && ord == 0)
				expected_results.push_back(make_result(0, j, j + 1 == total,
					bsp_pkg::STATUS_DEG0));
			else if (it.kind == bsp_pkg::KIND_ALL_VALUES)
				expected_results.push_back(make_result(basis_at(x, j, ord), j, j + 1 == total,
					bsp_pkg::STATUS_OK));
			else
				expected_results.push_back(make_result(slope_at(x, j, ord), j, j + 1 == total,
					bsp_pkg::STATUS_OK));
		end
	endtask

	// Register writes, result comparison and prediction, all sampled at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		bsp_pkg::out_item_t want;
		if (!arst_n) begin
			cur_order       = bsp_pkg::RST_SPLINE_ORDER;
			cur_count       = bsp_pkg::RST_BREAKPOINT_COUNT;
			cur_tol         = bsp_pkg::RST_TOLERANCE;
			fail_count      = 0;
			results_checked = 0;
			expected_results.delete();
			for (int j = 0; j < STORE_DEPTH; j++)
				bp_store[j] = '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					bsp_pkg::CFG_SPLINE_ORDER:     cur_order = cfg_data[1:0];
					bsp_pkg::CFG_BREAKPOINT_COUNT: cur_count = cfg_data[4:0];
					bsp_pkg::CFG_TOLERANCE:        cur_tol   = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				results_checked++;
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("checker: unexpected result value=%0d index=%0d",
							out_item.result_value, out_item.result_index);
				end else begin
					want = expected_results.pop_front();
					if (out_item !== want) begin
						fail_count++;
						// Fields in order: value, index, last, status.
						if (fail_count <= 10)
							$display("checker: expected %0d/%0d/%0b/%0d, got %0d/%0d/%0b/%0d",
								want.result_value, want.result_index, want.last, want.status,
								out_item.result_value, out_item.result_index, out_item.last,
								out_item.status);
					end
				end
			end
			if (in_valid && !in_stall)
				predict_results(in_item);
		end
		pending = expected_results.size();
	end

endmodule

@@ tb/sv/tb_bspline_basis_eval_unit.sv @@
// Testbench top for the B-spline basis evaluator: clock, reset, configuration phases,
// directed and random transactions, receiver stalls and the verdict.
// Depends on bsp_pkg, bspline_basis_eval_unit and bsp_checker.
`timescale 1ns / 1ps

module tb_bspline_basis_eval_unit;

	localparam int PHASES      = 8;
	localparam int CYCLE_LIMIT = 60000000;
	localparam int SETTLE      = 200;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	bsp_pkg::in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	bsp_pkg::out_item_t out_item;
	logic      cfg_write;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;
	int        fail_count;
	int        pending;
	int        results_checked;

	bit        quiet;
	bit        long_hold_req;
	int        cycles;
	int        sent;
	int        bp [16];
	int        act_count;

	bspline_basis_eval_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	bsp_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending), .results_checked(results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog on the total run length.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Receiver: random stall bursts, and one long hold-off when asked for.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				out_stall <= 1'b1;
				repeat (3000) @(negedge clk);
				out_stall <= 1'b0;
				long_hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Offers one transaction; called and returns at a falling edge.
	task automatic offer(input bsp_pkg::in_item_t it);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do
			@(posedge clk);
		while (in_stall);
		sent++;
		@(negedge clk);
	endtask

	function automatic bsp_pkg::in_item_t build(input logic [2:0] k, input int x, input int bi,
			input int deg);
		bsp_pkg::in_item_t it;
		it.kind             = k;
		it.breakpoint_index = $urandom_range(0, 15);
		it.point_value      = x;
		it.basis_index      = bi[4:0];
		it.degree           = deg[1:0];
		return it;
	endfunction

	task automatic load_point(input int idx, input int v);
		bsp_pkg::in_item_t it;
		it = build(bsp_pkg::KIND_LOAD, v, $urandom_range(0, 31), $urandom_range(0, 3));
		it.breakpoint_index = idx[3:0];
		bp[idx] = v;
		offer(it);
	endtask

	// Loads all sixteen breakpoints in one of several shapes.
	task automatic load_set();
		int     shape;
		longint v, stp;
		shape = $urandom_range(0, 3);
		v = (shape == 3) ? -64'sd1879048192 + $urandom_range(0, 65535)
			: longint'($urandom_range(0, 32'h0040_0000)) - 64'sd2097152;
		for (int j = 0; j < 16; j++) begin
			load_point(j, int'(v));
			case (shape)
				2:       stp = $urandom_range(0, 3);
				3:       stp = $urandom_range(0, 32'h0D00_0000);
				default: stp = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(32'h100, 32'h40000);
			endcase
			v += stp;
		end
	endtask

	// Evaluation point: mostly around the knots in use, sometimes on a knot or anywhere.
	function automatic int pick_x();
		longint lo, hi, span, r;
		int     sel;
		lo   = bp[0];
		hi   = bp[act_count - 1];
		span = (hi > lo) ? hi - lo : 64'sd65536;
		sel  = $urandom_range(0, 99);
		if (sel < 8)
			return int'($urandom);
		if (sel < 25)
			return bp[$urandom_range(0, act_count - 1)];
		r = longint'({$urandom, $urandom} & 64'h3FFF_FFFF_FFFF_FFFF) % (span * 5 / 4 + 1);
		r = lo - span / 8 + r;
		if (r > 64'sd2147483647)
			r = 64'sd2147483647;
		if (r < -64'sd2147483648)
			r = -64'sd2147483648;
		return int'(r);
	endfunction

	task automatic random_item();
		int sel, bi;
		sel = $urandom_range(0, 99);
		bi  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 18);
		if (sel < 6)
			load_point($urandom_range(0, 15), pick_x());
		else if (sel < 9)
			offer(build(3'($urandom_range(5, 7)), int'($urandom), bi, $urandom_range(0, 3)));
		else if (sel < 53)
			offer(build(bsp_pkg::KIND_VALUE, pick_x(), bi, $urandom_range(0, 3)));
		else if (sel < 85)
			offer(build(bsp_pkg::KIND_DERIV, pick_x(), bi, $urandom_range(0, 3)));
		else if (sel < 93)
			offer(build(bsp_pkg::KIND_ALL_VALUES, pick_x(), bi, $urandom_range(0, 3)));
		else
			offer(build(bsp_pkg::KIND_ALL_DERIVS, pick_x(), bi, $urandom_range(0, 3)));
	endtask

	// Lets every expected result arrive, then a pause before the unit counts as idle.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_regs(input int ord, input int cnt, input int tol);
		cfg_write <= 1'b1;
		cfg_index <= bsp_pkg::CFG_SPLINE_ORDER;
		cfg_data  <= 16'(ord);
		@(negedge clk);
		cfg_index <= bsp_pkg::CFG_BREAKPOINT_COUNT;
		cfg_data  <= 16'(cnt);
		@(negedge clk);
		cfg_index <= bsp_pkg::CFG_TOLERANCE;
		cfg_data  <= 16'(tol);
		@(negedge clk);
		cfg_write <= 1'b0;
		act_count = (cnt < 2) ? 2 : (cnt > 16) ? 16 : cnt;
	endtask

	// Directed part on four evenly spaced knots of a cubic spline.
	task automatic directed();
		for (int j = 0; j < 16; j++)
			load_point(j, j * 65536);
		load_point(15, 32'sh7FFF_FFFF);
		load_point(14, 32'sh8000_0000);
		offer(build(bsp_pkg::KIND_VALUE, 0, 3, 3));
		offer(build(bsp_pkg::KIND_VALUE, 3 * 65536, 5, 3));
		offer(build(bsp_pkg::KIND_VALUE, 98304, 2, 2));
		offer(build(bsp_pkg::KIND_VALUE, -65536, 0, 0));
		offer(build(bsp_pkg::KIND_DERIV, 98304, 2, 0));
		offer(build(bsp_pkg::KIND_DERIV, 98304, 2, 3));
		offer(build(bsp_pkg::KIND_VALUE, 65536, 31, 3));
		offer(build(bsp_pkg::KIND_DERIV, 65536, 17, 1));
		offer(build(bsp_pkg::KIND_ALL_VALUES, 81920, 0, 0));
		offer(build(bsp_pkg::KIND_ALL_DERIVS, 2 * 65536, 0, 0));
		offer(build(bsp_pkg::KIND_ALL_VALUES, 3 * 65536, 0, 0));
		offer(build(3'd5, 0, 0, 0));
		offer(build(3'd7, -1, 31, 3));
		offer(build(bsp_pkg::KIND_VALUE, 32'sh7FFF_FFFF, 4, 3));
		offer(build(bsp_pkg::KIND_VALUE, 32'sh8000_0000, 0, 3));
	endtask

	initial begin
		int orders [PHASES] = '{3, 0, 1, 2, 3, 0, 2, 1};
		int counts [PHASES] = '{4, 16, 2, 7, 16, 1, 31, 5};
		int tols   [PHASES] = '{1, 0, 65535, 300, 0, 40000, 16, 1};
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_item       = '0;
		cfg_write     = 1'b0;
		cfg_index     = bsp_pkg::CFG_SPLINE_ORDER;
		cfg_data      = '0;
		quiet         = 1'b0;
		long_hold_req = 1'b0;
		sent          = 0;
		act_count     = 2;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int p = 0; p < PHASES; p++) begin
			quiet = (p == PHASES - 1);
			write_regs(orders[p], counts[p], tols[p]);
			if (p == 0) begin
				directed();
			end else begin
				load_set();
				offer(build(bsp_pkg::KIND_ALL_DERIVS, pick_x(), 0, 0));
			end
			if (p == 3)
				long_hold_req = 1'b1;
			for (int n = 0; n < 34; n++)
				random_item();
			drain();
		end

		$display("Run covered %0d transactions over %0d register settings, %0d results checked.",
			sent, PHASES, results_checked);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
